/* design/blsc_pkg.sv */
// Shared types, constants and gain tables for the Bayer lens shading corrector.
// Used by blsc_div and bayer_lens_shading_correction_top; depends on nothing.

package blsc_pkg;

  localparam int unsigned PIX_W     = 12;
  localparam int unsigned COORD_W   = 13;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned MAX_DIM   = 8192;
  localparam int unsigned MIN_W     = 8;
  localparam int unsigned MIN_H     = 6;
  localparam int unsigned GRID_X    = 8;
  localparam int unsigned GRID_Y    = 6;
  localparam int unsigned IDX_W     = 3;
  // widest cell is under 2048 on either axis
  localparam int unsigned DIST_W    = 11;
  localparam int unsigned AREA_W    = 2 * DIST_W;
  localparam int unsigned GAIN_W    = 11;
  localparam int unsigned NUM_W     = AREA_W + GAIN_W;
  localparam int unsigned PIX_MAX   = 4095;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ROM_EVEN_E,
    ROM_MIXED_E,
    ROM_ODD_E
  } rom_sel_e;

  typedef logic [GAIN_W-1:0] gain_t;

  localparam gain_t ROM_EVEN [0:GRID_X*GRID_Y-1] = '{
    11'd1624, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1624, 11'd1824,
    11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1524, 11'd1724,
    11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
    11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
    11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1324, 11'd1624,
    11'd1824, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1524, 11'd1724
  };
  localparam gain_t ROM_MIXED [0:GRID_X*GRID_Y-1] = '{
    11'd1624, 11'd1524, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1624, 11'd1784,
    11'd1624, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1584, 11'd1664,
    11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
    11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
    11'd1524, 11'd1324, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1424, 11'd1664,
    11'd1724, 11'd1424, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1554, 11'd1784
  };
  localparam gain_t ROM_ODD [0:GRID_X*GRID_Y-1] = '{
    11'd1224, 11'd1154, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1184, 11'd1324,
    11'd1164, 11'd1124, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1124, 11'd1164,
    11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
    11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
    11'd1324, 11'd1224, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1264, 11'd1324,
    11'd1424, 11'd1264, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1314, 11'd1484
  };

  // Row y, column x of the table picked by phase; {y, x} equals y * 8 + x.
  function automatic gain_t rom_gain(input rom_sel_e sel, input logic [IDX_W-1:0] y,
                                     input logic [IDX_W-1:0] x);
    logic [2*IDX_W-1:0] a;
    gain_t g;
    a = {y, x};
    case (sel)
      ROM_MIXED_E: g = ROM_MIXED[a];
      ROM_ODD_E:   g = ROM_ODD[a];
      default:     g = ROM_EVEN[a];
    endcase
    return g;
  endfunction

  // floor(v / 7) for v below 57344, by reciprocal
  function automatic logic [COORD_W-1:0] div7(input logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(74899);
    return p[31:19];
  endfunction

  // floor(v / 5) for v below 40960, by reciprocal
  function automatic logic [COORD_W-1:0] div5(input logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(52429);
    return p[30:18];
  endfunction

endpackage

/* design/bayer_lens_shading_correction_top.sv */
// Bayer lens shading corrector: grid lookup, bilinear gain, pixel scaling.
// Depends on blsc_pkg and blsc_div.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, pixel_value_i, column_i, row_i | to block
//  out     | out_valid_o, out_ready_i, corrected_pixel_o    | from block
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i              | to block
//
// One word per clock unless the output word is held; from acceptance a word passes
// through 17 register stages: input, locate, weights, products, sum,
// 11 divider stages, scaling.
// The quotient pipeline sets the depth; one bit is settled per stage.
// Reset sets width 8 and height 6 and empties the pipeline.
// A held output word freezes every stage together; nothing is lost or repeated.

module bayer_lens_shading_correction_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [blsc_pkg::PIX_W-1:0]    pixel_value_i,
  input  logic [blsc_pkg::COORD_W-1:0]  column_i,
  input  logic [blsc_pkg::COORD_W-1:0]  row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blsc_pkg::PIX_W-1:0]    corrected_pixel_o,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [blsc_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned CW = blsc_pkg::COORD_W;
  localparam int unsigned DW = blsc_pkg::DIST_W;
  localparam int unsigned IW = blsc_pkg::IDX_W;
  localparam int unsigned SW = blsc_pkg::PIX_W + blsc_pkg::GAIN_W - blsc_pkg::FRAC_BITS;

  logic en;

  // ---------------- configuration and grid bounds
  logic [blsc_pkg::CFG_W-1:0] width_q, height_q;
  logic [CW-1:0] span_x, span_y;
  logic [CW-1:0] bx_d [blsc_pkg::GRID_X];
  logic [CW-1:0] by_d [blsc_pkg::GRID_Y];
  logic [CW-1:0] bx_q [blsc_pkg::GRID_X];
  logic [CW-1:0] by_q [blsc_pkg::GRID_Y];
  logic [CW-1:0] span_x_q, span_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= blsc_pkg::CFG_W'(blsc_pkg::MIN_W);
      height_q <= blsc_pkg::CFG_W'(blsc_pkg::MIN_H);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        blsc_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        blsc_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < blsc_pkg::CFG_W'(blsc_pkg::MIN_W)) begin
      span_x = CW'(blsc_pkg::MIN_W - 1);
    end else if (width_q > blsc_pkg::CFG_W'(blsc_pkg::MAX_DIM)) begin
      span_x = CW'(blsc_pkg::MAX_DIM - 1);
    end else begin
      span_x = CW'(width_q - 1'b1);
    end
    if (height_q < blsc_pkg::CFG_W'(blsc_pkg::MIN_H)) begin
      span_y = CW'(blsc_pkg::MIN_H - 1);
    end else if (height_q > blsc_pkg::CFG_W'(blsc_pkg::MAX_DIM)) begin
      span_y = CW'(blsc_pkg::MAX_DIM - 1);
    end else begin
      span_y = CW'(height_q - 1'b1);
    end
    for (int i = 0; i < blsc_pkg::GRID_X - 1; i++) begin
      bx_d[i] = blsc_pkg::div7(16'(i) * 16'(span_x));
    end
    bx_d[blsc_pkg::GRID_X-1] = span_x;
    for (int i = 0; i < blsc_pkg::GRID_Y - 1; i++) begin
      by_d[i] = blsc_pkg::div5(16'(i) * 16'(span_y));
    end
    by_d[blsc_pkg::GRID_Y-1] = span_y;
  end

  // registered bounds: a word accepted right after a write meets them at locate
  always_ff @(posedge clk_i) begin
    bx_q     <= bx_d;
    by_q     <= by_d;
    span_x_q <= span_x;
    span_y_q <= span_y;
  end

  // ---------------- stage 0: input register
  logic                       v0_q;
  logic [blsc_pkg::PIX_W-1:0] pix0_q;
  logic [CW-1:0]              col0_q, row0_q;

  // ---------------- stage 1: cell lookup
  logic                       v1_q;
  logic [blsc_pkg::PIX_W-1:0] pix1_q;
  logic [IW-1:0]              xi_d, yi_d, xi1_q, yi1_q;
  logic [DW-1:0]              x1_d, x2_d, y1_d, y2_d;
  logic [DW-1:0]              x1_q, x2_q, y1_q, y2_q;
  blsc_pkg::rom_sel_e         sel_d, sel1_q;
  logic [CW-1:0]              cs, rs;

  always_comb begin
    cs = (col0_q > span_x_q) ? span_x_q : col0_q;
    rs = (row0_q > span_y_q) ? span_y_q : row0_q;
    xi_d = IW'(blsc_pkg::GRID_X - 2);
    for (int i = blsc_pkg::GRID_X - 1; i >= 1; i--) begin
      if (cs <= bx_q[i]) xi_d = IW'(i - 1);
    end
    yi_d = IW'(blsc_pkg::GRID_Y - 2);
    for (int i = blsc_pkg::GRID_Y - 1; i >= 1; i--) begin
      if (rs <= by_q[i]) yi_d = IW'(i - 1);
    end
    x1_d = DW'(cs - bx_q[xi_d]);
    x2_d = DW'(bx_q[xi_d + 1'b1] - cs);
    y1_d = DW'(rs - by_q[yi_d]);
    y2_d = DW'(by_q[yi_d + 1'b1] - rs);
    if (!col0_q[0] && !row0_q[0]) begin
      sel_d = blsc_pkg::ROM_EVEN_E;
    end else if (col0_q[0] && row0_q[0]) begin
      sel_d = blsc_pkg::ROM_ODD_E;
    end else begin
      sel_d = blsc_pkg::ROM_MIXED_E;
    end
  end

  // ---------------- stage 2: corner gains, weights and area
  logic                       v2_q;
  logic [blsc_pkg::PIX_W-1:0] pix2_q;
  blsc_pkg::gain_t            g00_q, g01_q, g10_q, g11_q;
  logic [blsc_pkg::AREA_W-1:0] w00_q, w01_q, w10_q, w11_q, area2_q;

  // ---------------- stage 3: weighted corners
  logic                       v3_q;
  logic [blsc_pkg::PIX_W-1:0] pix3_q;
  logic [blsc_pkg::NUM_W-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [blsc_pkg::AREA_W-1:0] area3_q;

  // ---------------- stage 4: numerator
  logic                       v4_q;
  logic [blsc_pkg::PIX_W-1:0] pix4_q;
  logic [blsc_pkg::NUM_W-1:0] num4_q;
  logic [blsc_pkg::AREA_W-1:0] area4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix0_q  <= pixel_value_i;
      col0_q  <= column_i;
      row0_q  <= row_i;

      pix1_q  <= pix0_q;
      xi1_q   <= xi_d;
      yi1_q   <= yi_d;
      x1_q    <= x1_d;
      x2_q    <= x2_d;
      y1_q    <= y1_d;
      y2_q    <= y2_d;
      sel1_q  <= sel_d;

      pix2_q  <= pix1_q;
      g00_q   <= blsc_pkg::rom_gain(sel1_q, yi1_q, xi1_q);
      g01_q   <= blsc_pkg::rom_gain(sel1_q, yi1_q, xi1_q + 1'b1);
      g10_q   <= blsc_pkg::rom_gain(sel1_q, yi1_q + 1'b1, xi1_q);
      g11_q   <= blsc_pkg::rom_gain(sel1_q, yi1_q + 1'b1, xi1_q + 1'b1);
      w00_q   <= blsc_pkg::AREA_W'(x2_q) * blsc_pkg::AREA_W'(y2_q);
      w01_q   <= blsc_pkg::AREA_W'(x1_q) * blsc_pkg::AREA_W'(y2_q);
      w10_q   <= blsc_pkg::AREA_W'(x2_q) * blsc_pkg::AREA_W'(y1_q);
      w11_q   <= blsc_pkg::AREA_W'(x1_q) * blsc_pkg::AREA_W'(y1_q);
      area2_q <= blsc_pkg::AREA_W'(x1_q + x2_q) * blsc_pkg::AREA_W'(y1_q + y2_q);

      pix3_q  <= pix2_q;
      p00_q   <= blsc_pkg::NUM_W'(w00_q) * blsc_pkg::NUM_W'(g00_q);
      p01_q   <= blsc_pkg::NUM_W'(w01_q) * blsc_pkg::NUM_W'(g01_q);
      p10_q   <= blsc_pkg::NUM_W'(w10_q) * blsc_pkg::NUM_W'(g10_q);
      p11_q   <= blsc_pkg::NUM_W'(w11_q) * blsc_pkg::NUM_W'(g11_q);
      area3_q <= area2_q;

      pix4_q  <= pix3_q;
      num4_q  <= p00_q + p01_q + p10_q + p11_q;
      area4_q <= area3_q;
    end
  end

  // ---------------- divide by cell area
  logic                        vd;
  logic [blsc_pkg::GAIN_W-1:0] gain_d;
  logic [blsc_pkg::PIX_W-1:0]  pixd;

  blsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num4_q),
    .den_i   (area4_q),
    .pix_i   (pix4_q),
    .valid_o (vd),
    .quot_o  (gain_d),
    .pix_o   (pixd)
  );

  // ---------------- scale, clip and output register
  logic [blsc_pkg::PIX_W+blsc_pkg::GAIN_W-1:0] prod;
  logic [SW-1:0]              scaled;
  logic [blsc_pkg::PIX_W-1:0] res_d, res_q;
  logic                       out_valid_q;

  always_comb begin
    prod   = (blsc_pkg::PIX_W + blsc_pkg::GAIN_W)'(pixd)
           * (blsc_pkg::PIX_W + blsc_pkg::GAIN_W)'(gain_d);
    scaled = prod[blsc_pkg::PIX_W+blsc_pkg::GAIN_W-1:blsc_pkg::FRAC_BITS];
    if (scaled > SW'(blsc_pkg::PIX_MAX)) begin
      res_d = blsc_pkg::PIX_W'(blsc_pkg::PIX_MAX);
    end else begin
      res_d = blsc_pkg::PIX_W'(scaled);
    end
  end

  // advance the whole pipeline unless a finished word is held
  assign en = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o        = en;
  assign out_valid_o       = out_valid_q;
  assign corrected_pixel_o = res_q;

endmodule

/* design/blsc_div.sv */
// Pipelined restoring divider: one quotient bit per stage, pixel carried alongside.
// Depends on blsc_pkg.

module blsc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [blsc_pkg::NUM_W-1:0]      num_i,
  input  logic [blsc_pkg::AREA_W-1:0]     den_i,
  input  logic [blsc_pkg::PIX_W-1:0]      pix_i,
  output logic                            valid_o,
  output logic [blsc_pkg::GAIN_W-1:0]     quot_o,
  output logic [blsc_pkg::PIX_W-1:0]      pix_o
);

  localparam int unsigned NS = blsc_pkg::GAIN_W;

  logic [NS-1:0]                   valid_q;
  logic [blsc_pkg::NUM_W-1:0]      rem_q  [NS];
  logic [blsc_pkg::AREA_W-1:0]     den_q  [NS];
  logic [blsc_pkg::GAIN_W-1:0]     quot_q [NS];
  logic [blsc_pkg::PIX_W-1:0]      pix_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [blsc_pkg::NUM_W-1:0]  rem_in, rem_d, dsh;
    logic [blsc_pkg::AREA_W-1:0] den_in;
    logic [blsc_pkg::GAIN_W-1:0] quot_in, quot_d;
    logic [blsc_pkg::PIX_W-1:0]  pix_in;
    logic                        v_in;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign pix_in  = pix_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign pix_in  = pix_q[k-1];
      assign v_in    = valid_q[k-1];
    end

    // this stage settles quotient bit NS-1-k
    always_comb begin
      dsh    = blsc_pkg::NUM_W'(den_in) << (NS - 1 - k);
      rem_d  = rem_in;
      quot_d = quot_in;
      if (rem_in >= dsh) begin
        rem_d  = rem_in - dsh;
        quot_d = quot_in | (blsc_pkg::GAIN_W'(1) << (NS - 1 - k));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quot_q[k] <= quot_d;
        pix_q[k]  <= pix_in;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign quot_o  = quot_q[NS-1];
  assign pix_o   = pix_q[NS-1];

endmodule
